@@ sv/wwvtc_pkg.sv @@
// shared types, constants and arithmetic helpers for the wwv time-code segment encoder
`default_nettype none
package wwvtc_pkg;

  localparam int unsigned SYMS_PER_SEG = 10;
  localparam int unsigned CNT_W        = $clog2(SYMS_PER_SEG);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SYMS_PER_SEG - 1);

  typedef enum logic [1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_MARK  = 2'd2,
    SYM_BLANK = 2'd3
  } sym_e;

  // segment selector codes
  localparam logic [2:0] SEG_NONE  = 3'd0;
  localparam logic [2:0] SEG_ONE   = 3'd1;
  localparam logic [2:0] SEG_TWO   = 3'd2;
  localparam logic [2:0] SEG_THREE = 3'd3;
  localparam logic [2:0] SEG_FOUR  = 3'd4;
  localparam logic [2:0] SEG_FIVE  = 3'd5;

  // symbol k of a segment sits at index k
  typedef logic [SYMS_PER_SEG-1:0][1:0] seg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        dst;
  } req_t;

  typedef struct packed {
    logic [2:0] sel;
    logic       dst;
    logic       leap;
    logic [3:0] year_ones;
    logic [3:0] minute_ones;
    logic [3:0] minute_tens;
    logic [3:0] hour_ones;
    logic [3:0] hour_tens;
    logic [8:0] doy;
  } fields_t;

  // floor(x / 10) for x below 128
  function automatic logic [3:0] div10_7(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  // days in the months before month m, with m clamped to 1..12, february as 28
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

  function automatic logic [9:0] on_ms_of(input sym_e s);
    logic [9:0] v;
    case (s)
      SYM_ZERO: v = 10'd170;
      SYM_ONE:  v = 10'd470;
      SYM_MARK: v = 10'd770;
      default:  v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] off_ms_of(input sym_e s);
    logic [9:0] v;
    case (s)
      SYM_ZERO: v = 10'd830;
      SYM_ONE:  v = 10'd530;
      SYM_MARK: v = 10'd230;
      default:  v = 10'd1000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/wwv_time_code_segment_encoder.sv @@
// top level of the wwv time-code segment encoder
`default_nettype none
// Each request (start_i high while busy_o is low) names one 10-second time-code
// segment and a date and time; the block answers with ten results on
// consecutive cycles, each marked by valid_o for one cycle, with last_o on the
// tenth. The receiver cannot stall, so results must be taken as they appear.
// A request passes an input register, a decode register and then the result
// shift register, in that order, before its first symbol shows on the outputs.
// The shift register sends one symbol per cycle and sets the rate: segments are
// sent back to back, and a new request is taken while the previous segment is
// still being sent, up to two ahead of the one on the outputs.
module wwv_time_code_segment_encoder import wwvtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic        dst_i,
  output logic        valid_o,
  output logic [1:0]  symbol_o,
  output logic [9:0]  on_ms_o,
  output logic [9:0]  off_ms_o,
  output logic        last_o
);

  logic    req_v_q, req_v_d;
  req_t    req_q;
  logic    fld_v_q, fld_v_d;
  fields_t fld_q, fld_d;
  seg_t    seg;
  logic    ser_rdy;
  logic    load;
  logic    fld_free;
  logic    adv;
  logic    accept;

  assign load     = fld_v_q && ser_rdy;
  assign fld_free = !fld_v_q || ser_rdy;
  assign adv      = req_v_q && fld_free;
  assign busy_o   = req_v_q && !fld_free;
  assign accept   = start_i && !busy_o;

  assign req_v_d = accept || (req_v_q && !adv);
  assign fld_v_d = adv || (fld_v_q && !load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
      fld_v_q <= 1'b0;
    end else begin
      req_v_q <= req_v_d;
      fld_v_q <= fld_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= '{req_type: req_type_i, year: year_i, month: month_i, day: day_i,
                 hour: hour_i, minute: minute_i, dst: dst_i};
    end
    if (adv) begin
      fld_q <= fld_d;
    end
  end

  wwvtc_decode u_decode (
    .req_i (req_q),
    .fld_o (fld_d)
  );

  wwvtc_pack u_pack (
    .fld_i (fld_q),
    .seg_o (seg)
  );

  wwvtc_serial u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .seg_i    (seg),
    .ready_o  (ser_rdy),
    .valid_o  (valid_o),
    .symbol_o (symbol_o),
    .on_ms_o  (on_ms_o),
    .off_ms_o (off_ms_o),
    .last_o   (last_o)
  );

endmodule
`default_nettype wire

@@ sv/wwvtc_decode.sv @@
// first pass: leap year, year ones digit, bcd digits of hour and minute, day of year
`default_nettype none
module wwvtc_decode import wwvtc_pkg::*; (
  input  req_t    req_i,
  output fields_t fld_o
);

  logic [29:0] y10_prod;
  logic [10:0] y_div10;
  logic [3:0]  y10_low;
  logic [27:0] y100_prod;
  logic [7:0]  y_div100;
  logic [13:0] y100_back;
  logic        cent;
  logic        leap;
  logic [3:0]  m_tens;
  logic [3:0]  h_tens;
  logic        past_feb;

  always_comb begin
    // year / 10 and year / 100 by reciprocal, exact over the 14-bit range
    y10_prod  = 30'(req_i.year) * 30'd52429;
    y_div10   = y10_prod[29:19];
    y10_low   = 4'({y_div10, 3'b000} + {y_div10, 1'b0});
    y100_prod = 28'(req_i.year) * 28'd10486;
    y_div100  = y100_prod[27:20];
    y100_back = 14'({y_div100, 6'b0}) + 14'({y_div100, 5'b0}) + 14'({y_div100, 2'b0});
    cent      = (y100_back == req_i.year);
    leap      = (req_i.year[1:0] == 2'b00) && (!cent || (y_div100[1:0] == 2'b00));

    m_tens   = div10_7({1'b0, req_i.minute});
    h_tens   = div10_7({2'b00, req_i.hour});
    past_feb = (req_i.month >= 4'd3);

    fld_o.sel         = req_i.req_type;
    fld_o.dst         = req_i.dst;
    fld_o.leap        = leap;
    fld_o.year_ones   = req_i.year[3:0] - y10_low;
    fld_o.minute_tens = m_tens;
    fld_o.minute_ones = req_i.minute[3:0] - 4'({m_tens, 3'b000} + {m_tens, 1'b0});
    fld_o.hour_tens   = h_tens;
    fld_o.hour_ones   = req_i.hour[3:0] - 4'({h_tens, 3'b000} + {h_tens, 1'b0});
    fld_o.doy         = days_before(req_i.month) + 9'(req_i.day)
                        + 9'(past_feb && leap);
  end

endmodule
`default_nettype wire

@@ sv/wwvtc_pack.sv @@
// second pass: day-of-year digits and layout of the ten symbols of the segment
`default_nettype none
module wwvtc_pack import wwvtc_pkg::*; (
  input  fields_t fld_i,
  output seg_t    seg_o
);

  logic [3:0] d_hund;
  logic [8:0] d_base;
  logic [6:0] d_rem;
  logic [3:0] d_tens;
  logic [3:0] d_ones;

  function automatic seg_t put_bcd(input seg_t s, input int unsigned pos, input logic [3:0] dig);
    seg_t r;
    r = s;
    for (int unsigned b = 0; b < 4; b++) begin
      r[pos + b] = {1'b0, dig[b]};
    end
    return r;
  endfunction

  always_comb begin
    if (fld_i.doy >= 9'd300) begin
      d_hund = 4'd3;
      d_base = 9'd300;
    end else if (fld_i.doy >= 9'd200) begin
      d_hund = 4'd2;
      d_base = 9'd200;
    end else if (fld_i.doy >= 9'd100) begin
      d_hund = 4'd1;
      d_base = 9'd100;
    end else begin
      d_hund = 4'd0;
      d_base = 9'd0;
    end
    d_rem  = 7'(fld_i.doy - d_base);
    d_tens = div10_7(d_rem);
    d_ones = d_rem[3:0] - 4'({d_tens, 3'b000} + {d_tens, 1'b0});

    seg_o = {SYMS_PER_SEG{SYM_BLANK}};
    case (fld_i.sel)
      SEG_ONE: begin
        seg_o[1] = SYM_ZERO;
        seg_o[2] = {1'b0, fld_i.dst};
        seg_o[3] = {1'b0, fld_i.leap};
        seg_o    = put_bcd(seg_o, 4, fld_i.year_ones);
        seg_o[8] = SYM_ZERO;
        seg_o[9] = SYM_MARK;
      end
      SEG_TWO: begin
        seg_o    = put_bcd(seg_o, 0, fld_i.minute_ones);
        seg_o[4] = SYM_ZERO;
        seg_o    = put_bcd(seg_o, 5, fld_i.minute_tens);
        seg_o[9] = SYM_MARK;
      end
      SEG_THREE: begin
        seg_o    = put_bcd(seg_o, 0, fld_i.hour_ones);
        seg_o[4] = SYM_ZERO;
        seg_o    = put_bcd(seg_o, 5, fld_i.hour_tens);
        seg_o[9] = SYM_MARK;
      end
      SEG_FOUR: begin
        seg_o    = put_bcd(seg_o, 0, d_ones);
        seg_o[4] = SYM_ZERO;
        seg_o    = put_bcd(seg_o, 5, d_tens);
        seg_o[9] = SYM_MARK;
      end
      SEG_FIVE: begin
        seg_o    = put_bcd(seg_o, 0, d_hund);
        seg_o[4] = SYM_ZERO;
      end
      default: begin
        seg_o = {SYMS_PER_SEG{SYM_BLANK}};
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/wwvtc_serial.sv @@
// result shift register: sends the ten symbols of a segment one per cycle
`default_nettype none
module wwvtc_serial import wwvtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  seg_t       seg_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [1:0] symbol_o,
  output logic [9:0] on_ms_o,
  output logic [9:0] off_ms_o,
  output logic       last_o
);

  logic             act_q, act_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  seg_t             sh_q, sh_d;
  logic             at_last;

  assign at_last = (cnt_q == CNT_LAST);
  // a new segment can load on the cycle its predecessor sends its tenth symbol
  assign ready_o = !act_q || at_last;

  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    sh_d  = sh_q;
    if (load_i) begin
      act_d = 1'b1;
      cnt_d = '0;
      sh_d  = seg_i;
    end else if (act_q) begin
      if (at_last) begin
        act_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        sh_d  = {SYM_BLANK, sh_q[SYMS_PER_SEG-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      act_q <= act_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign valid_o  = act_q;
  assign symbol_o = sh_q[0];
  assign on_ms_o  = on_ms_of(sym_e'(sh_q[0]));
  assign off_ms_o = off_ms_of(sym_e'(sh_q[0]));
  assign last_o   = act_q && at_last;

  // a segment runs unbroken until its tenth symbol
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("symbol stream broke before the last symbol");

  // a load only lands on an idle register or over the last symbol
  a_load_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!act_q || at_last))
    else $error("segment loaded over one still being sent");

  // every segment starts at symbol zero
  a_start_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_o && cnt_q == '0))
    else $error("segment did not start at its first symbol");

  // symbol counter advances by one while not at the end
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && !at_last && !load_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("symbol counter skipped");

endmodule
`default_nettype wire
